@@ rtl/core/glf_pkg.sv @@
// Shared types and constants of the greedy line fill block.
package glf_pkg;

  // Byte codes
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_BREAK = 8'h0A;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int FILL_W  = 6;
  localparam int COL_W   = 8;
  localparam int TUSER_W = 2;

  // Tab stop spacing
  localparam int TAB_STOP = 8;

  // Result cap per input beat, and the width of a counter that can hold it
  localparam int MAX_RESULTS = 64;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Release sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_RD_REQ,
    ST_WORDS,
    ST_TAIL
  } state_t;

endpackage

@@ rtl/core/glf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module glf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/greedy_line_fill.sv @@
// Greedy word wrap of a paragraph byte stream to a programmable fill column.
//
//  channel | direction | tdata                | tuser                      | tlast
//  --------+-----------+----------------------+----------------------------+-----------
//  in_     | sink      | [7:0] text_byte      | -                          | para_last
//  out_    | source    | [7:0] out_byte       | [0] is_break [1] para_done | run_end
//  cfg_    | sink      | [5:0] fill_column    | -                          | -
//
// An input beat is taken while the sequencer is idle; its results then drain
// through a small release sequencer: a head step for the held whitespace, a
// read request step to start the word store read, a words step per stored word
// byte, a tail step for the trailing byte. A beat with no result leaves the
// sequencer idle. Output stalls hold the sequencer; the output register lets
// the next input beat be taken while the last result still waits. Reset is
// synchronous, active low, and empties the word store logically (count to zero).
module greedy_line_fill #(
  parameter int WORD_DEPTH = 63
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [glf_pkg::BYTE_W-1:0]    in_tdata,   // [7:0] text_byte
  input  logic                          in_tlast,
  // Result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [glf_pkg::BYTE_W-1:0]    out_tdata,  // [7:0] out_byte
  output logic [glf_pkg::TUSER_W-1:0]   out_tuser,  // [0] is_break, [1] para_done
  output logic                          out_tlast,
  // Configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [glf_pkg::FILL_W-1:0]    cfg_data
);

  import glf_pkg::*;

  localparam int AW   = $clog2(WORD_DEPTH);
  localparam int WC_W = $clog2(WORD_DEPTH + 1);

  // Architectural state
  state_t              state_r, state_nxt;
  logic [FILL_W-1:0]   fill_r;
  logic [COL_W-1:0]    column_r, column_nxt;
  logic                held_valid_r, held_valid_nxt;
  logic [BYTE_W-1:0]   held_byte_r, held_byte_nxt;
  logic [WC_W-1:0]     word_count_r, word_count_nxt;

  // Release plan of the beat in flight
  logic [BYTE_W-1:0]    head_byte_r, head_byte_nxt;
  logic [WC_W-1:0]      nw_r, nw_nxt;
  logic                 tail_v_r, tail_v_nxt;
  logic [BYTE_W-1:0]    tail_byte_r, tail_byte_nxt;
  logic                 tail_brk_r, tail_brk_nxt;
  logic                 last_r, last_nxt;
  logic [WC_W-1:0]      idx_r, idx_nxt;
  logic [RES_CNT_W-1:0] n_r, n_nxt;
  logic                 head_v_plan;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]    out_byte_r, out_byte_nxt;
  logic                 out_brk_r, out_brk_nxt;
  logic                 out_end_r, out_end_nxt;
  logic                 out_pd_r, out_pd_nxt;

  // Word store
  logic                 wr_en;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [BYTE_W-1:0]    rd_data;

  // Sequencer handshake
  logic                 in_acc;
  logic                 slot_free;
  logic                 go;
  logic                 emit;
  logic                 more;
  logic [BYTE_W-1:0]    emit_byte;
  logic                 emit_brk;
  logic [WC_W-1:0]      idx_inc;

  // Plan arithmetic
  logic                 is_ws;
  logic [COL_W:0]       c_wide;
  logic [COL_W-1:0]     c_sat;
  logic                 past_fill;
  logic                 pending;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || out_tready;
  assign idx_inc   = idx_r + WC_W'(1);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_pd_r, out_brk_r};
  assign out_tlast  = out_end_r;

  glf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WORD_DEPTH)
  ) u_word_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (word_count_r[AW-1:0]),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Column arithmetic for the incoming byte
  always_comb begin
    is_ws = (in_tdata == CHAR_SPACE) || (in_tdata == CHAR_TAB);
    if (in_tdata == CHAR_TAB) begin
      c_wide = ({1'b0, column_r} + (COL_W+1)'(TAB_STOP)) & ~((COL_W+1)'(TAB_STOP - 1));
    end else begin
      c_wide = {1'b0, column_r} + (COL_W+1)'(1);
    end
    c_sat     = c_wide[COL_W] ? {COL_W{1'b1}} : c_wide[COL_W-1:0];
    past_fill = c_sat > {{(COL_W-FILL_W){1'b0}}, fill_r};
    pending   = held_valid_r && (held_byte_r != CHAR_BREAK);
  end

  // Decide new state and release plan when a beat is taken
  always_comb begin
    column_nxt     = column_r;
    held_valid_nxt = held_valid_r;
    held_byte_nxt  = held_byte_r;
    word_count_nxt = word_count_r;
    head_byte_nxt  = head_byte_r;
    nw_nxt         = nw_r;
    tail_v_nxt     = tail_v_r;
    tail_byte_nxt  = tail_byte_r;
    tail_brk_nxt   = tail_brk_r;
    last_nxt       = last_r;
    head_v_plan    = 1'b0;
    wr_en          = 1'b0;
    if (in_acc) begin
      last_nxt      = in_tlast;
      head_byte_nxt = held_byte_r;
      head_v_plan   = held_valid_r;
      nw_nxt        = word_count_r;
      tail_v_nxt    = 1'b1;
      tail_byte_nxt = in_tdata;
      tail_brk_nxt  = 1'b0;
      if (is_ws) begin
        // Release what is held, then hold this whitespace
        held_byte_nxt  = past_fill ? CHAR_BREAK : in_tdata;
        held_valid_nxt = 1'b1;
        word_count_nxt = '0;
        column_nxt     = past_fill ? '0 : c_sat;
        tail_v_nxt     = in_tlast;
        tail_byte_nxt  = past_fill ? CHAR_BREAK : in_tdata;
        tail_brk_nxt   = past_fill;
      end else if (pending && past_fill) begin
        // Word overflows: the held whitespace turns into a break
        head_byte_nxt  = CHAR_BREAK;
        held_byte_nxt  = CHAR_BREAK;
        held_valid_nxt = 1'b0;
        word_count_nxt = '0;
        column_nxt     = {{(COL_W-WC_W){1'b0}}, word_count_r} + COL_W'(1);
      end else if (pending && (word_count_r == WC_W'(WORD_DEPTH))) begin
        // Store full: release as plain bytes
        held_valid_nxt = 1'b0;
        word_count_nxt = '0;
        column_nxt     = c_sat;
      end else if (pending) begin
        // Withhold the word byte
        wr_en          = 1'b1;
        word_count_nxt = word_count_r + WC_W'(1);
        column_nxt     = c_sat;
        tail_v_nxt     = 1'b0;
        head_v_plan    = in_tlast;
        nw_nxt         = in_tlast ? word_count_r + WC_W'(1) : '0;
      end else begin
        // Nothing pending: pass the byte through
        held_valid_nxt = 1'b0;
        word_count_nxt = '0;
        column_nxt     = c_sat;
      end
      if (in_tlast) begin
        column_nxt     = '0;
        held_valid_nxt = 1'b0;
        word_count_nxt = '0;
      end
    end
  end

  // Sequencer outputs: what to emit and whether the step advances
  always_comb begin
    emit_byte = head_byte_r;
    emit_brk  = 1'b0;
    more      = 1'b0;
    go        = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx_r[AW-1:0];
    case (state_r)
      ST_HEAD: begin
        emit_byte = head_byte_r;
        emit_brk  = (head_byte_r == CHAR_BREAK);
        more      = (nw_r != '0) || tail_v_r;
        go        = (n_r == RES_CNT_W'(MAX_RESULTS)) || slot_free;
      end
      ST_RD_REQ: begin
        rd_en = 1'b1;
        go    = 1'b1;
      end
      ST_WORDS: begin
        emit_byte = rd_data;
        more      = (idx_inc != nw_r) || tail_v_r;
        go        = (n_r == RES_CNT_W'(MAX_RESULTS)) || slot_free;
        if (go && (idx_inc != nw_r)) begin
          rd_en   = 1'b1;
          rd_addr = idx_inc[AW-1:0];
        end
      end
      ST_TAIL: begin
        emit_byte = tail_byte_r;
        emit_brk  = tail_brk_r;
        go        = (n_r == RES_CNT_W'(MAX_RESULTS)) || slot_free;
      end
      default: begin
        go = 1'b0;
      end
    endcase
    emit = go && (state_r != ST_RD_REQ) && (state_r != ST_IDLE)
           && (n_r != RES_CNT_W'(MAX_RESULTS));
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (head_v_plan) begin
            state_nxt = ST_HEAD;
          end else if (nw_nxt != '0) begin
            state_nxt = ST_RD_REQ;
          end else if (tail_v_nxt) begin
            state_nxt = ST_TAIL;
          end
        end
      end
      ST_HEAD: begin
        if (go) begin
          if (nw_r != '0) begin
            state_nxt = ST_RD_REQ;
          end else if (tail_v_r) begin
            state_nxt = ST_TAIL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RD_REQ: begin
        state_nxt = ST_WORDS;
      end
      ST_WORDS: begin
        if (go && (idx_inc == nw_r)) begin
          state_nxt = tail_v_r ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result counter, word index and output register
  always_comb begin
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_brk_nxt   = out_brk_r;
    out_end_nxt   = out_end_r;
    out_pd_nxt    = out_pd_r;
    if (in_acc) begin
      n_nxt   = '0;
      idx_nxt = '0;
    end
    if ((state_r == ST_WORDS) && go) begin
      idx_nxt = idx_inc;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      n_nxt         = n_r + RES_CNT_W'(1);
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_brk_nxt   = emit_brk;
      out_end_nxt   = !more || (n_r == RES_CNT_W'(MAX_RESULTS - 1));
      out_pd_nxt    = last_r && (!more || (n_r == RES_CNT_W'(MAX_RESULTS - 1)));
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= FILL_W'(63);
      column_r     <= '0;
      held_valid_r <= 1'b0;
      word_count_r <= '0;
      out_valid_r  <= 1'b0;
      n_r          <= '0;
      idx_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      column_r     <= column_nxt;
      held_valid_r <= held_valid_nxt;
      word_count_r <= word_count_nxt;
      out_valid_r  <= out_valid_nxt;
      n_r          <= n_nxt;
      idx_r        <= idx_nxt;
      if (cfg_valid && cfg_ready) begin
        fill_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    held_byte_r <= held_byte_nxt;
    head_byte_r <= head_byte_nxt;
    nw_r        <= nw_nxt;
    tail_v_r    <= tail_v_nxt;
    tail_byte_r <= tail_byte_nxt;
    tail_brk_r  <= tail_brk_nxt;
    last_r      <= last_nxt;
    out_byte_r  <= out_byte_nxt;
    out_brk_r   <= out_brk_nxt;
    out_end_r   <= out_end_nxt;
    out_pd_r    <= out_pd_nxt;
  end

  // A paragraph end leaves the line state empty
  a_para_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=>
      (column_r == '0) && !held_valid_r && (word_count_r == '0))
    else $error("line state not cleared after paragraph end");

  // Withheld bytes never exceed the store
  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    word_count_r <= WC_W'(WORD_DEPTH))
    else $error("word count beyond store depth");

  // Never more results than the cap for one beat
  a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= RES_CNT_W'(MAX_RESULTS))
    else $error("result count beyond cap");

  // The paragraph end flag only rides on the last result of a beat
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("para_done without run_end");

endmodule

@@ verif/greedy_line_fill_tb.sv @@
// Self-checking testbench for the greedy line fill block: directed, back-pressure and random text.
module greedy_line_fill_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import glf_pkg::*;

  localparam int WORD_DEPTH     = 63;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 20;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_t;

  // One expected output beat
  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              brk;
    logic              run_end;
    logic              para_done;
  } wrap_res_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [BYTE_W-1:0]    in_tdata = '0;   // [7:0] text_byte
  logic                 in_tlast = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [BYTE_W-1:0]    out_tdata;       // [7:0] out_byte
  logic [TUSER_W-1:0]   out_tuser;       // [0] is_break, [1] para_done
  logic                 out_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [FILL_W-1:0]    cfg_data = '0;

  // Wrap predictor state
  logic [FILL_W-1:0]    m_fill;
  logic [COL_W-1:0]     m_col;
  logic                 m_held_v;
  logic [BYTE_W-1:0]    m_held;
  logic [BYTE_W-1:0]    m_word [WORD_DEPTH];
  int                   m_wcount;
  int                   m_nres;
  wrap_res_t            wrapped_q [$];

  // Stimulus and checking state
  int                   err_count = 0;
  int                   idle_cycles = 0;
  int                   burst_left = 0;
  bit                   gaps_on = 1'b0;
  rx_mode_t             rx_mode = RX_ALWAYS;
  logic [7:0]           rx_pattern = 8'b1011_0110;
  bit                   hold_request = 1'b0;
  int                   hold_left = 0;

  greedy_line_fill #(
    .WORD_DEPTH(WORD_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Wrap predictor
  // ---------------------------------------------------------------------------

  function automatic void emit(logic [BYTE_W-1:0] b, logic brk);
    if (m_nres < MAX_RESULTS) begin
      wrapped_q.push_back('{data: b, brk: brk, run_end: 1'b0, para_done: 1'b0});
      m_nres++;
    end
  endfunction

  // Release the held whitespace and the word bytes queued behind it
  function automatic void release_held();
    if (m_held_v)
      emit(m_held, m_held == CHAR_BREAK);
    m_held_v = 1'b0;
    for (int i = 0; i < m_wcount; i++)
      emit(m_word[i], 1'b0);
    m_wcount = 0;
  endfunction

  function automatic void wrap_byte(logic [BYTE_W-1:0] b, logic last);
    int        c;
    wrap_res_t r;
    m_nres = 0;
    if (b == CHAR_SPACE || b == CHAR_TAB) begin
      release_held();
      if (b == CHAR_TAB)
        c = (int'(m_col) + TAB_STOP) & ~(TAB_STOP - 1);
      else
        c = int'(m_col) + 1;
      if (c > 255)
        c = 255;
      if (c > int'(m_fill)) begin
        m_held = CHAR_BREAK;
        c = 0;
      end else begin
        m_held = b;
      end
      m_held_v = 1'b1;
      m_col = c[COL_W-1:0];
    end else begin
      c = int'(m_col) + 1;
      if (c > 255)
        c = 255;
      if (m_held_v && m_held != CHAR_BREAK) begin
        if (c > int'(m_fill)) begin
          // Word overran the line: the whitespace in front of it breaks
          m_held = CHAR_BREAK;
          c = m_wcount + 1;
          release_held();
          emit(b, 1'b0);
        end else if (m_wcount >= WORD_DEPTH) begin
          release_held();
          emit(b, 1'b0);
        end else begin
          m_word[m_wcount] = b;
          m_wcount++;
        end
      end else begin
        release_held();
        emit(b, 1'b0);
      end
      m_col = c[COL_W-1:0];
    end
    if (last) begin
      release_held();
      m_col = '0;
    end
    // Tag the final beat of this input
    if (m_nres > 0) begin
      r = wrapped_q.pop_back();
      r.run_end = 1'b1;
      r.para_done = last;
      wrapped_q.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker and watchdog
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    wrap_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (wrapped_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected beat, expected none, got byte %0h user %0h last %0b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        want = wrapped_q.pop_front();
        check_field("out_byte",  32'(want.data),      32'(out_tdata));
        check_field("is_break",  32'(want.brk),       32'(out_tuser[0]));
        check_field("run_end",   32'(want.run_end),   32'(out_tlast));
        check_field("para_done", 32'(want.para_done), 32'(out_tuser[1]));
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d beats still expected", $time, wrapped_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern plus an occasional long hold-off
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
        default: begin
          rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
          out_tready <= rx_pattern[0];
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------

  // Offer one beat; valid stays high after acceptance until the next drive
  task automatic send_byte(logic [BYTE_W-1:0] b, logic last);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0)
      burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    wrap_byte(b, last);
  endtask

  task automatic send_string(string s, logic last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], last && i == s.len() - 1);
  endtask

  function automatic logic [BYTE_W-1:0] word_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255)); while (b == CHAR_SPACE || b == CHAR_TAB);
    return b;
  endfunction

  // Stop offering and wait until every expected beat has arrived
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (wrapped_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_fill(logic [FILL_W-1:0] v);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    m_fill = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed words and whitespace runs, some raw noise bytes
  task automatic send_text(int n_items);
    int                sent;
    int                len;
    logic              end_para;
    logic [BYTE_W-1:0] grp [$];
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        end_para = ($urandom_range(0, 7) == 0);
        grp.delete();
        repeat (len) grp.push_back(word_byte());
        repeat ($urandom_range(0, 3))
          grp.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
        foreach (grp[i])
          send_byte(grp[i], end_para && i == grp.size() - 1);
        sent += grp.size();
      end else begin
        send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero byte, all-ones byte, both whitespace codes, alternating bit patterns
  task automatic test_byte_extremes();
    write_fill(6'd63);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CHAR_SPACE, 1'b0);
    send_byte(CHAR_TAB, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
  endtask

  // A word that overruns the line turns the space before it into a break
  task automatic test_break_at_word();
    write_fill(6'd8);
    send_string("ab cdefgh", 1'b1);
  endtask

  // With a zero fill column every whitespace breaks
  task automatic test_fill_zero();
    write_fill(6'd0);
    send_string("a \tb", 1'b1);
  endtask

  // Tab advances to the next stop and is kept, then breaks on overrun
  task automatic test_tab_stop();
    write_fill(6'd12);
    send_string("a\tbcdef", 1'b1);
  endtask

  // A word longer than the widest line: the fullest release, then a tab that breaks
  task automatic test_long_word();
    write_fill(6'd63);
    send_byte(CHAR_SPACE, 1'b0);
    repeat (70) send_byte(word_byte(), 1'b0);
    send_byte(CHAR_TAB, 1'b0);
    send_byte(CHAR_SPACE, 1'b1);
  endtask

  // Hold off the receiver while text keeps coming, so the input stalls
  task automatic test_backpressure();
    write_fill(6'd20);
    gaps_on = 1'b0;
    rx_mode = RX_ALWAYS;
    hold_request = 1'b1;
    send_text(30);
    drain_results();
  endtask

  // Random paragraphs over several fill columns and stall patterns
  task automatic test_random_text();
    logic [FILL_W-1:0] fills [5];
    fills = '{6'd1, 6'd63, 6'd0, FILL_W'($urandom_range(2, 62)), FILL_W'($urandom_range(2, 20))};
    foreach (fills[p]) begin
      write_fill(fills[p]);
      gaps_on = (p != 1);
      rx_mode = (p == 1) ? RX_ALWAYS : rx_mode_t'($urandom_range(1, 2));
      rx_pattern = {7'($urandom_range(1, 127)), 1'b1};
      send_text(16);
    end
  endtask

  initial begin
    m_fill   = 6'd63;
    m_col    = '0;
    m_held_v = 1'b0;
    m_held   = '0;
    m_wcount = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_byte_extremes();
    test_break_at_word();
    test_fill_zero();
    test_tab_stop();
    gaps_on = 1'b1;
    rx_mode = RX_RANDOM;
    test_long_word();
    test_backpressure();
    test_random_text();

    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
